@@ rtl/ptlc_pkg.sv @@
// Package for the pedestrian traffic light controller.
// Phase codes, lamp and result structs, register indexes, reset values.
// No dependencies.
package ptlc_pkg;

  localparam int CNT_W       = 16;
  localparam int BLINK_W     = 3;
  localparam int MAIN_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int BLINK_STEPS_DEF = 5;

  localparam logic [CNT_W-1:0] LONG_PHASE_RST  = 16'd5000;
  localparam logic [CNT_W-1:0] BLINK_PERIOD_RST = 16'd1000;
  localparam logic [CNT_W-1:0] PRESS_HOLD_RST  = 16'd1000;

  typedef enum logic [2:0] {
    PH_GREEN   = 3'd0,
    PH_YELLOW  = 3'd1,
    PH_RED     = 3'd2,
    PH_QUALIFY = 3'd3,
    PH_WARN    = 3'd4,
    PH_WALK    = 3'd5,
    PH_CLEAR   = 3'd6
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PHASE   = 2'd0,
    REG_BLINK_PERIOD = 2'd1,
    REG_PRESS_HOLD   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] long_phase;
    logic [CNT_W-1:0] blink_period;
    logic [CNT_W-1:0] press_hold;
  } cfg_t;

  typedef struct packed {
    logic car_green;
    logic car_yellow;
    logic car_red;
    logic walk_green;
    logic walk_yellow;
    logic walk_red;
  } lamps_t;

  typedef struct packed {
    lamps_t lamps;
    phase_t phase;
  } result_t;

  typedef struct packed {
    logic advance;
    logic level;
  } item_ctl_t;

  function automatic lamps_t lamps_of(phase_t ph, logic blink_on);
    lamps_t l;
    l = '0;
    case (ph)
      PH_YELLOW: begin
        l.car_yellow = blink_on;
        l.walk_red   = 1'b1;
      end
      PH_RED, PH_WALK: begin
        l.car_red    = 1'b1;
        l.walk_green = 1'b1;
      end
      PH_WARN: begin
        l.car_yellow  = blink_on;
        l.walk_yellow = blink_on;
        l.walk_red    = 1'b1;
      end
      PH_CLEAR: begin
        l.car_yellow  = blink_on;
        l.walk_yellow = blink_on;
        l.walk_green  = 1'b1;
      end
      default: begin
        l.car_green = 1'b1;
        l.walk_red  = 1'b1;
      end
    endcase
    return l;
  endfunction

endpackage

@@ rtl/pedestrian_traffic_light_controller.sv @@
// Pedestrian traffic light controller, top level.
// Depends on ptlc_pkg, ptlc_cfg_regs, ptlc_in_stage, ptlc_fsm, ptlc_out_stage.
//
// Each item is one time-base tick carrying the button level, and yields one
// result item: six lamp levels and the phase code. An item is taken into an
// input register, passes the phase state machine and lands in a result
// register, from which its result is offered. While the result side is not
// stalled, one item is taken every cycle; with it stalled the input register
// still takes one more item. Phase lengths, blink period and press hold
// time are counted in ticks and may be rewritten through the configuration
// port, which takes a write in every cycle; a value of zero acts as one tick.
module pedestrian_traffic_light_controller #(
  parameter int BLINK_STEPS = ptlc_pkg::BLINK_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_button_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_car_green,
  output logic                            out_car_yellow,
  output logic                            out_car_red,
  output logic                            out_walk_green,
  output logic                            out_walk_yellow,
  output logic                            out_walk_red,
  output logic [2:0]                      out_phase_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptlc_pkg::CNT_W-1:0]      cfg_data
);

  ptlc_pkg::cfg_t      cfg;
  ptlc_pkg::item_ctl_t item;
  ptlc_pkg::result_t   res;
  ptlc_pkg::result_t   out_res;
  logic                out_take;

  assign cfg_ready = 1'b1;

  ptlc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ptlc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_level (in_button_level),
    .out_take (out_take),
    .item     (item)
  );

  ptlc_fsm #(
    .BLINK_STEPS (BLINK_STEPS)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  ptlc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (item.advance),
    .res       (res),
    .out_take  (out_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_car_green   = out_res.lamps.car_green;
  assign out_car_yellow  = out_res.lamps.car_yellow;
  assign out_car_red     = out_res.lamps.car_red;
  assign out_walk_green  = out_res.lamps.walk_green;
  assign out_walk_yellow = out_res.lamps.walk_yellow;
  assign out_walk_red    = out_res.lamps.walk_red;
  assign out_phase_code  = out_res.phase;

endmodule

@@ rtl/ptlc_cfg_regs.sv @@
// Configuration registers of the traffic light controller.
// Depends on ptlc_pkg.
module ptlc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ptlc_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ptlc_pkg::CNT_W-1:0]       wr_data,
  output ptlc_pkg::cfg_t                   cfg
);

  ptlc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_phase   <= ptlc_pkg::LONG_PHASE_RST;
      cfg_r.blink_period <= ptlc_pkg::BLINK_PERIOD_RST;
      cfg_r.press_hold   <= ptlc_pkg::PRESS_HOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        ptlc_pkg::REG_LONG_PHASE:   cfg_r.long_phase   <= wr_data;
        ptlc_pkg::REG_BLINK_PERIOD: cfg_r.blink_period <= wr_data;
        ptlc_pkg::REG_PRESS_HOLD:   cfg_r.press_hold   <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/ptlc_in_stage.sv @@
// Input register of the traffic light controller: one tick item.
// Depends on ptlc_pkg.
module ptlc_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_level,
  input  logic                 out_take,
  output ptlc_pkg::item_ctl_t  item
);

  logic valid_r;
  logic level_r;
  logic advance;

  assign advance  = valid_r & out_take;
  assign in_ready = ~valid_r | out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r <= in_level;
    end
  end

  assign item.advance = advance;
  assign item.level   = level_r;

endmodule

@@ rtl/ptlc_fsm.sv @@
// Phase state machine: button edge, qualify, tick and blink counters, lamps.
// Depends on ptlc_pkg.
module ptlc_fsm #(
  parameter int BLINK_STEPS = ptlc_pkg::BLINK_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptlc_pkg::item_ctl_t  item,
  input  ptlc_pkg::cfg_t       cfg,
  output ptlc_pkg::result_t    res
);

  localparam logic [ptlc_pkg::BLINK_W-1:0] BLINK_LAST = ptlc_pkg::BLINK_W'(BLINK_STEPS);
  localparam logic [ptlc_pkg::MAIN_W-1:0]  MAIN_GREEN = ptlc_pkg::MAIN_W'(ptlc_pkg::PH_GREEN);
  localparam logic [ptlc_pkg::MAIN_W-1:0]  MAIN_RED   = ptlc_pkg::MAIN_W'(ptlc_pkg::PH_RED);

  ptlc_pkg::phase_t                  phase_r, phase_nxt, cur_phase;
  logic [ptlc_pkg::MAIN_W-1:0]       prior_r, prior_nxt;
  logic [ptlc_pkg::MAIN_W-1:0]       frozen_r, frozen_nxt, cur_frozen;
  logic [ptlc_pkg::CNT_W-1:0]        tick_r, tick_nxt, tick_inc;
  logic [ptlc_pkg::BLINK_W-1:0]      blink_r, blink_nxt, blink_inc;
  logic [ptlc_pkg::CNT_W-1:0]        hold_r, hold_nxt, cur_hold, hold_inc;
  logic                              btn_prior_r, btn_prior_nxt;
  logic                              btn_rise;
  logic                              long_done;
  logic                              period_done;
  logic                              blink_end;
  ptlc_pkg::phase_t                  show_phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ptlc_pkg::PH_GREEN;
      prior_r     <= MAIN_GREEN;
      frozen_r    <= '0;
      tick_r      <= '0;
      blink_r     <= '0;
      hold_r      <= '0;
      btn_prior_r <= 1'b0;
    end else if (item.advance) begin
      phase_r     <= phase_nxt;
      prior_r     <= prior_nxt;
      frozen_r    <= frozen_nxt;
      tick_r      <= tick_nxt;
      blink_r     <= blink_nxt;
      hold_r      <= hold_nxt;
      btn_prior_r <= btn_prior_nxt;
    end
  end

  always_comb begin
    btn_rise   = item.level & ~btn_prior_r;
    cur_phase  = phase_r;
    cur_frozen = frozen_r;
    cur_hold   = hold_r;
    if (btn_rise && (phase_r == ptlc_pkg::PH_GREEN || phase_r == ptlc_pkg::PH_YELLOW ||
                     phase_r == ptlc_pkg::PH_RED)) begin
      cur_frozen = phase_r[ptlc_pkg::MAIN_W-1:0];
      cur_phase  = ptlc_pkg::PH_QUALIFY;
      cur_hold   = '0;
    end

    show_phase = (cur_phase == ptlc_pkg::PH_QUALIFY) ?
                 ptlc_pkg::phase_t'({1'b0, cur_frozen}) : cur_phase;
    res.lamps  = ptlc_pkg::lamps_of(show_phase, ~blink_r[0]);
    res.phase  = cur_phase;

    tick_inc    = tick_r + 1'b1;
    hold_inc    = cur_hold + 1'b1;
    blink_inc   = blink_r + 1'b1;
    long_done   = tick_inc >= cfg.long_phase;
    period_done = tick_inc >= cfg.blink_period;
    blink_end   = blink_inc >= BLINK_LAST;

    phase_nxt     = cur_phase;
    prior_nxt     = prior_r;
    frozen_nxt    = cur_frozen;
    tick_nxt      = tick_inc;
    blink_nxt     = blink_r;
    hold_nxt      = cur_hold;
    btn_prior_nxt = item.level;

    case (cur_phase)
      ptlc_pkg::PH_GREEN, ptlc_pkg::PH_RED: begin
        if (long_done) begin
          prior_nxt = cur_phase[ptlc_pkg::MAIN_W-1:0];
          phase_nxt = ptlc_pkg::PH_YELLOW;
          tick_nxt  = '0;
          blink_nxt = '0;
        end
      end
      ptlc_pkg::PH_YELLOW, ptlc_pkg::PH_WARN, ptlc_pkg::PH_CLEAR: begin
        if (period_done) begin
          tick_nxt  = '0;
          blink_nxt = blink_inc;
          if (blink_end) begin
            blink_nxt = '0;
            case (cur_phase)
              ptlc_pkg::PH_YELLOW:
                phase_nxt = (prior_r == MAIN_GREEN) ? ptlc_pkg::PH_RED : ptlc_pkg::PH_GREEN;
              ptlc_pkg::PH_WARN:
                phase_nxt = ptlc_pkg::PH_WALK;
              default: begin
                prior_nxt = cur_frozen;
                phase_nxt = ptlc_pkg::PH_GREEN;
              end
            endcase
          end
        end
      end
      ptlc_pkg::PH_QUALIFY: begin
        tick_nxt = tick_r;
        if (!item.level) begin
          phase_nxt = ptlc_pkg::phase_t'({1'b0, cur_frozen});
        end else if (hold_inc >= cfg.press_hold) begin
          hold_nxt  = '0;
          phase_nxt = (cur_frozen == MAIN_RED) ? ptlc_pkg::PH_WALK : ptlc_pkg::PH_WARN;
          tick_nxt  = '0;
          blink_nxt = '0;
        end else begin
          hold_nxt = hold_inc;
        end
      end
      ptlc_pkg::PH_WALK: begin
        if (long_done) begin
          phase_nxt = ptlc_pkg::PH_CLEAR;
          tick_nxt  = '0;
          blink_nxt = '0;
        end
      end
      default: begin
        phase_nxt = ptlc_pkg::PH_GREEN;
        tick_nxt  = '0;
        blink_nxt = '0;
      end
    endcase
  end

endmodule

@@ rtl/ptlc_out_stage.sv @@
// Result register of the traffic light controller: lamps and phase code.
// Depends on ptlc_pkg.
module ptlc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  ptlc_pkg::result_t    res,
  output logic                 out_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptlc_pkg::result_t    out_res
);

  logic              valid_r;
  ptlc_pkg::result_t res_r;

  assign out_take = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_take) begin
      valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/ptlc_checker.sv @@
// Port-level checker for the traffic light controller, bound to the top level.
// Depends on ptlc_pkg.
module ptlc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_car_green,
  input logic       out_car_yellow,
  input logic       out_car_red,
  input logic       out_walk_green,
  input logic       out_walk_yellow,
  input logic       out_walk_red,
  input logic [2:0] out_phase_code
);

  logic [5:0] lamps;
  assign lamps = {out_car_green, out_car_yellow, out_car_red,
                  out_walk_green, out_walk_yellow, out_walk_red};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(lamps) && $stable(out_phase_code))
    else $error("result item changed while stalled");

  a_walk_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_walk_green ^ out_walk_red) && !(out_car_green && out_car_red))
    else $error("conflicting lamps lit");

  a_green_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase_code == 3'(ptlc_pkg::PH_GREEN)
      |-> out_car_green && out_walk_red && !out_car_yellow && !out_walk_yellow)
    else $error("car green phase shows wrong lamps");

  a_walk_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase_code == 3'(ptlc_pkg::PH_WALK) ||
                  out_phase_code == 3'(ptlc_pkg::PH_RED))
      |-> out_car_red && out_walk_green && !out_car_green)
    else $error("walk phase shows wrong lamps");

endmodule

bind pedestrian_traffic_light_controller ptlc_checker u_ptlc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_car_green   (out_car_green),
  .out_car_yellow  (out_car_yellow),
  .out_car_red     (out_car_red),
  .out_walk_green  (out_walk_green),
  .out_walk_yellow (out_walk_yellow),
  .out_walk_red    (out_walk_red),
  .out_phase_code  (out_phase_code)
);
